@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker of the order book.
// Depends on a clock named clk and an active low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("order book assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("order book assertion failed");

`endif

@@ rtl/lobm_pkg.sv @@
// Types and codes of the limit order book matcher.
// No dependencies; used by the top level and the checker of the block.
package lobm_pkg;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_CANCEL = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUP       = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic        side;
    logic [11:0] order_id;
    logic [7:0]  price;
    logic [15:0] quantity;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] filled_quantity;
    logic [15:0] rested_quantity;
    logic [7:0]  best_bid;
    logic        bid_valid;
    logic [7:0]  best_ask;
    logic        ask_valid;
  } out_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ID_RD, S_CAN_RD, S_MATCH, S_LV_RD, S_SL_RD,
    S_REL_A, S_REL_B, S_REL_P, S_REL_NX, S_REL_N, S_REL_FIN,
    S_REST, S_REST_A, S_REST_B, S_FIN
  } state_e;

endpackage

@@ rtl/lobm_ram.sv @@
// Single write port, single read port synchronous memory with a registered read.
// No dependencies.
module lobm_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lobm_best.sv @@
// Non-empty level bitmap of both sides and its two-stage best price search.
// Depends on nothing but its parameter; a write reaches the results through the group and then the output registers.
module lobm_best #(
  parameter int PRICE_LEVELS = 256,
  localparam int PW = $clog2(PRICE_LEVELS),
  localparam int LW = PW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ne_we,
  input  logic [LW-1:0] ne_idx,
  input  logic          ne_val,
  input  logic [LW-1:0] q_idx,
  output logic          q_ne,
  output logic [PW-1:0] bid_lvl,
  output logic          bid_vld,
  output logic [PW-1:0] ask_lvl,
  output logic          ask_vld
);

  localparam int GB = 4;
  localparam int G  = 1 << GB;
  localparam int NG = (PRICE_LEVELS + G - 1) / G;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;

  logic [2*PRICE_LEVELS-1:0] ne_r;
  logic [NG*G-1:0]           pad_b, pad_a;
  logic [GW-1:0]             gb_nxt, ga_nxt, gb_r, ga_r;
  logic                      vb_nxt, va_nxt, vb_r, va_r;
  logic [G-1:0]              wb, wa;
  logic [GB-1:0]             bb, ba;

  assign q_ne = ne_r[q_idx];

  always_comb begin
    pad_b = '0;
    pad_a = '0;
    pad_b[PRICE_LEVELS-1:0] = ne_r[PRICE_LEVELS-1:0];
    pad_a[PRICE_LEVELS-1:0] = ne_r[2*PRICE_LEVELS-1:PRICE_LEVELS];
    gb_nxt = '0;
    ga_nxt = '0;
    vb_nxt = 1'b0;
    va_nxt = 1'b0;
    // Bids want the highest group, asks the lowest.
    for (int g = 0; g < NG; g++) begin
      if (|pad_b[g*G +: G]) begin
        gb_nxt = GW'(g);
        vb_nxt = 1'b1;
      end
    end
    for (int g = NG - 1; g >= 0; g--) begin
      if (|pad_a[g*G +: G]) begin
        ga_nxt = GW'(g);
        va_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    wb = pad_b[gb_r*G +: G];
    wa = pad_a[ga_r*G +: G];
    bb = '0;
    ba = '0;
    for (int b = 0; b < G; b++) begin
      if (wb[b]) begin
        bb = GB'(b);
      end
    end
    for (int b = G - 1; b >= 0; b--) begin
      if (wa[b]) begin
        ba = GB'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ne_r    <= '0;
      gb_r    <= '0;
      ga_r    <= '0;
      vb_r    <= 1'b0;
      va_r    <= 1'b0;
      bid_lvl <= '0;
      ask_lvl <= '0;
      bid_vld <= 1'b0;
      ask_vld <= 1'b0;
    end else begin
      if (ne_we) begin
        ne_r[ne_idx] <= ne_val;
      end
      gb_r    <= gb_nxt;
      ga_r    <= ga_nxt;
      vb_r    <= vb_nxt;
      va_r    <= va_nxt;
      bid_lvl <= vb_r ? PW'({gb_r, bb}) : '0;
      ask_lvl <= va_r ? PW'({ga_r, ba}) : '0;
      bid_vld <= vb_r;
      ask_vld <= va_r;
    end
  end

endmodule

@@ rtl/limit_order_book_matcher_unit.sv @@
// Top level of the limit order book matcher: command sequencer and order memories.
// Depends on lobm_pkg, lobm_ram and lobm_best.
//
// One command is taken at a rising edge where start is high and busy is low.
// Its single result is shown on out_data for one cycle with out_valid high,
// and the receiver cannot stall it. The order, level, id and free slot memories
// each have one write port, one read port and a registered read, so the
// sequencer issues each read in the state before the one that uses its data.
// A rejected command or a zero quantity add goes straight to the result.
// A cancel releases its order from the book; an add matches against resting
// orders, releases each one that it fills completely and rests any remainder.
// busy drops in the result cycle, so the next command can be taken at the edge
// that takes the result. After reset the block stays busy while it clears the
// id map and fills the free slot stack.
module limit_order_book_matcher_unit
  import lobm_pkg::*;
#(
  parameter int PRICE_LEVELS = 256,
  parameter int ORDER_SLOTS  = 1024,
  parameter int ID_SPACE     = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int PW    = $clog2(PRICE_LEVELS);
  localparam int LW    = PW + 1;
  localparam int SW    = $clog2(ORDER_SLOTS);
  localparam int SPW   = SW + 1;
  localparam int IDW   = $clog2(ID_SPACE);
  localparam int CLR_N = (ID_SPACE > ORDER_SLOTS) ? ID_SPACE : ORDER_SLOTS;
  localparam int CW    = $clog2(CLR_N);
  localparam logic [SPW-1:0] NO_SLOT = SPW'(ORDER_SLOTS);

  typedef struct packed {
    logic [SPW-1:0] nxt;
    logic [SPW-1:0] prv;
    logic [15:0]    qty;
    logic [IDW-1:0] owner;
    logic [LW-1:0]  lvl;
  } slot_t;

  typedef struct packed {
    logic [SPW-1:0] head;
    logic [SPW-1:0] tail;
  } lvl_t;

  typedef struct packed {
    logic          vld;
    logic [SW-1:0] slot;
  } idw_t;

  state_e        state_r, state_nxt;
  in_t           in_r, in_nxt;
  logic [15:0]   qty_r, qty_nxt, filled_r, filled_nxt, rested_r, rested_nxt;
  logic [1:0]    status_r, status_nxt;
  slot_t         sd_r, sd_nxt;
  logic [SW-1:0] s_r, s_nxt, t_r, t_nxt;
  logic          ret_r, ret_nxt;
  logic [SW:0]   fc_r, fc_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  logic [1:0]    settle_r;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;

  logic          sl_we, lv_we, id_we, fr_we;
  logic [SW-1:0] sl_wa, sl_ra, fr_wa, fr_ra;
  logic [LW-1:0] lv_wa, lv_ra;
  logic [IDW-1:0] id_wa, id_ra;
  slot_t         sl_wd, sl_rd;
  lvl_t          lv_wd, lv_rd;
  idw_t          id_wd, id_rd;
  logic [SW-1:0] fr_wd, fr_rd;

  logic          ne_we, ne_val, q_ne;
  logic [LW-1:0] ne_idx, q_idx;
  logic [PW-1:0] bid_lvl, ask_lvl, bp;
  logic          bid_vld, ask_vld, bv, best_ok, id_ok, crosses;
  logic [15:0]   take;

  lobm_ram #(.W($bits(slot_t)), .D(ORDER_SLOTS)) u_slot (
    .clk, .we(sl_we), .waddr(sl_wa), .wdata(sl_wd), .raddr(sl_ra), .rdata(sl_rd)
  );
  lobm_ram #(.W($bits(lvl_t)), .D(2*PRICE_LEVELS)) u_level (
    .clk, .we(lv_we), .waddr(lv_wa), .wdata(lv_wd), .raddr(lv_ra), .rdata(lv_rd)
  );
  lobm_ram #(.W($bits(idw_t)), .D(ID_SPACE)) u_idmap (
    .clk, .we(id_we), .waddr(id_wa), .wdata(id_wd), .raddr(id_ra), .rdata(id_rd)
  );
  lobm_ram #(.W(SW), .D(ORDER_SLOTS)) u_free (
    .clk, .we(fr_we), .waddr(fr_wa), .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd)
  );

  lobm_best #(.PRICE_LEVELS(PRICE_LEVELS)) u_best (
    .clk, .rst_n, .ne_we, .ne_idx, .ne_val, .q_idx, .q_ne,
    .bid_lvl, .bid_vld, .ask_lvl, .ask_vld
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign best_ok   = (settle_r == 2'd0);
  assign id_ok     = (32'(in_r.order_id) < ID_SPACE);
  assign bp        = in_r.side ? bid_lvl : ask_lvl;
  assign bv        = in_r.side ? bid_vld : ask_vld;
  assign crosses   = in_r.side ? (32'(bp) >= 32'(in_r.price))
                               : (32'(bp) <= 32'(in_r.price));
  assign take      = (qty_r < sl_rd.qty) ? qty_r : sl_rd.qty;

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    qty_nxt       = qty_r;
    filled_nxt    = filled_r;
    rested_nxt    = rested_r;
    status_nxt    = status_r;
    sd_nxt        = sd_r;
    s_nxt         = s_r;
    t_nxt         = t_r;
    ret_nxt       = ret_r;
    fc_nxt        = fc_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    sl_we = 1'b0; sl_wa = '0; sl_wd = sl_rd; sl_ra = '0;
    lv_we = 1'b0; lv_wa = '0; lv_wd = lv_rd; lv_ra = '0;
    id_we = 1'b0; id_wa = '0; id_wd = '0;    id_ra = '0;
    fr_we = 1'b0; fr_wa = '0; fr_wd = '0;    fr_ra = '0;
    ne_we = 1'b0; ne_idx = '0; ne_val = 1'b0;
    q_idx = {in_r.side, PW'(in_r.price)};

    case (state_r)
      S_CLEAR: begin
        if (32'(clr_r) < ID_SPACE) begin
          id_we = 1'b1;
          id_wa = IDW'(clr_r);
        end
        if (32'(clr_r) < ORDER_SLOTS) begin
          fr_we = 1'b1;
          fr_wa = SW'(clr_r);
          fr_wd = SW'(ORDER_SLOTS - 1 - 32'(clr_r));
        end
        clr_nxt = clr_r + CW'(1);
        if (32'(clr_r) == CLR_N - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        id_ra = IDW'(in_data.order_id);
        if (start) begin
          in_nxt     = in_data;
          qty_nxt    = in_data.quantity;
          filled_nxt = '0;
          rested_nxt = '0;
          status_nxt = ST_OK;
          state_nxt  = S_ID_RD;
        end
      end
      S_ID_RD: begin
        if (in_r.cmd == CMD_CANCEL) begin
          if (id_ok && id_rd.vld) begin
            s_nxt     = id_rd.slot;
            sl_ra     = id_rd.slot;
            ret_nxt   = 1'b0;
            state_nxt = S_CAN_RD;
          end else begin
            status_nxt = ST_NOT_FOUND;
            state_nxt  = S_FIN;
          end
        end else if (in_r.quantity == 16'd0) begin
          state_nxt = S_FIN;
        end else if (id_ok && id_rd.vld) begin
          status_nxt = ST_DUP;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_MATCH;
        end
      end
      S_CAN_RD: begin
        sd_nxt    = sl_rd;
        state_nxt = S_REL_A;
      end
      S_MATCH: begin
        lv_ra = {~in_r.side, bp};
        if (best_ok) begin
          state_nxt = (qty_r != 16'd0 && bv && crosses) ? S_LV_RD : S_REST;
        end
      end
      S_LV_RD: begin
        s_nxt     = SW'(lv_rd.head);
        sl_ra     = SW'(lv_rd.head);
        state_nxt = S_SL_RD;
      end
      S_SL_RD: begin
        qty_nxt    = qty_r - take;
        filled_nxt = filled_r + take;
        if (sl_rd.qty == take) begin
          sd_nxt    = sl_rd;
          ret_nxt   = 1'b1;
          state_nxt = S_REL_A;
        end else begin
          sl_we     = 1'b1;
          sl_wa     = s_r;
          sl_wd.qty = sl_rd.qty - take;
          state_nxt = S_MATCH;
        end
      end
      S_REL_A: begin
        lv_ra     = sd_r.lvl;
        state_nxt = S_REL_B;
      end
      S_REL_B: begin
        lv_we = 1'b1;
        lv_wa = sd_r.lvl;
        if (sd_r.prv == NO_SLOT) begin
          lv_wd.head = sd_r.nxt;
        end
        if (sd_r.nxt == NO_SLOT) begin
          lv_wd.tail = sd_r.prv;
        end
        if (sd_r.prv == NO_SLOT && sd_r.nxt == NO_SLOT) begin
          ne_we  = 1'b1;
          ne_idx = sd_r.lvl;
          ne_val = 1'b0;
        end
        sl_ra     = SW'(sd_r.prv);
        state_nxt = (sd_r.prv != NO_SLOT) ? S_REL_P : S_REL_NX;
      end
      S_REL_P: begin
        sl_we     = 1'b1;
        sl_wa     = SW'(sd_r.prv);
        sl_wd.nxt = sd_r.nxt;
        state_nxt = S_REL_NX;
      end
      S_REL_NX: begin
        sl_ra     = SW'(sd_r.nxt);
        state_nxt = (sd_r.nxt != NO_SLOT) ? S_REL_N : S_REL_FIN;
      end
      S_REL_N: begin
        sl_we     = 1'b1;
        sl_wa     = SW'(sd_r.nxt);
        sl_wd.prv = sd_r.prv;
        state_nxt = S_REL_FIN;
      end
      S_REL_FIN: begin
        id_we = 1'b1;
        id_wa = sd_r.owner;
        if (32'(fc_r) < ORDER_SLOTS) begin
          fr_we  = 1'b1;
          fr_wa  = SW'(fc_r);
          fr_wd  = s_r;
          fc_nxt = fc_r + 1'b1;
        end
        state_nxt = ret_r ? S_MATCH : S_FIN;
      end
      S_REST: begin
        fr_ra = SW'(fc_r - 1'b1);
        lv_ra = {in_r.side, PW'(in_r.price)};
        if (qty_r == 16'd0 || 32'(in_r.price) >= PRICE_LEVELS || !id_ok) begin
          state_nxt = S_FIN;
        end else if (fc_r == '0) begin
          status_nxt = ST_FULL;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_REST_A;
        end
      end
      S_REST_A: begin
        fc_nxt      = fc_r - 1'b1;
        s_nxt       = fr_rd;
        t_nxt       = SW'(lv_rd.tail);
        sl_we       = 1'b1;
        sl_wa       = fr_rd;
        sl_wd.nxt   = NO_SLOT;
        sl_wd.prv   = q_ne ? lv_rd.tail : NO_SLOT;
        sl_wd.qty   = qty_r;
        sl_wd.owner = IDW'(in_r.order_id);
        sl_wd.lvl   = q_idx;
        lv_we       = 1'b1;
        lv_wa       = q_idx;
        lv_wd.head  = q_ne ? lv_rd.head : SPW'(fr_rd);
        lv_wd.tail  = SPW'(fr_rd);
        ne_we       = 1'b1;
        ne_idx      = q_idx;
        ne_val      = 1'b1;
        id_we       = 1'b1;
        id_wa       = IDW'(in_r.order_id);
        id_wd.vld   = 1'b1;
        id_wd.slot  = fr_rd;
        rested_nxt  = qty_r;
        sl_ra       = SW'(lv_rd.tail);
        state_nxt   = q_ne ? S_REST_B : S_FIN;
      end
      S_REST_B: begin
        // Link the old tail of the level to the order that now rests behind it.
        sl_we     = 1'b1;
        sl_wa     = t_r;
        sl_wd.nxt = SPW'(s_r);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (best_ok) begin
          out_valid_nxt           = 1'b1;
          out_nxt.status          = status_r;
          out_nxt.filled_quantity = filled_r;
          out_nxt.rested_quantity = rested_r;
          out_nxt.best_bid        = 8'(bid_lvl);
          out_nxt.bid_valid       = bid_vld;
          out_nxt.best_ask        = 8'(ask_lvl);
          out_nxt.ask_valid       = ask_vld;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      fc_r        <= (SW+1)'(ORDER_SLOTS);
      settle_r    <= 2'd0;
      out_valid_r <= 1'b0;
      ret_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fc_r        <= fc_nxt;
      out_valid_r <= out_valid_nxt;
      ret_r       <= ret_nxt;
      // Hold off use of the best price after a bitmap change until both search registers have updated.
      if (ne_we) begin
        settle_r <= 2'd2;
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r     <= in_nxt;
    qty_r    <= qty_nxt;
    filled_r <= filled_nxt;
    rested_r <= rested_nxt;
    status_r <= status_nxt;
    sd_r     <= sd_nxt;
    s_r      <= s_nxt;
    t_r      <= t_nxt;
    out_r    <= out_nxt;
  end

endmodule

@@ rtl/lobm_checker.sv @@
// Port level checks of the order book matcher, bound to its top level.
// Depends on lobm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lobm_checker
  import lobm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  logic unused_in;
  logic book_ok, miss_ok;
  assign unused_in = ^in_data;
  assign book_ok   = !(out_data.bid_valid && out_data.ask_valid) ||
                     (out_data.best_bid < out_data.best_ask);
  assign miss_ok   = (out_data.status != ST_NOT_FOUND) ||
                     (out_data.filled_quantity == 16'd0 && out_data.rested_quantity == 16'd0);

  `ASSERT_NEXT(a_take_sets_busy, start && !busy, busy)
  `ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `ASSERT_SAME(a_result_when_idle, out_valid, !busy)
  `ASSERT_SAME(a_book_not_crossed, out_valid, book_ok)
  `ASSERT_SAME(a_cancel_miss_empty, out_valid, miss_ok)

endmodule

bind limit_order_book_matcher_unit lobm_checker u_lobm_checker (.*);
